// File: sv/deadline_task_queue_defines.svh
// Assertion macros shared by the deadline task queue modules.
`ifndef DEADLINE_TASK_QUEUE_DEFINES_SVH
`define DEADLINE_TASK_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtq assertion failed");

// Next-cycle implication, checked outside reset.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtq assertion failed");

`endif

// File: sv/dtq_pkg.sv
// Shared types, codes and control structs of the deadline task queue.
package dtq_pkg;

  localparam int ACT_W  = 2;
  localparam int ID_W   = 16;
  localparam int TIME_W = 32;
  localparam int KIND_W = 2;

  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam act_t ACT_POST     = 2'd0;
  localparam act_t ACT_CANCEL   = 2'd1;
  localparam act_t ACT_TICK     = 2'd2;
  localparam act_t ACT_SHUTDOWN = 2'd3;

  localparam kind_t KIND_ACCEPT  = 2'd0;
  localparam kind_t KIND_REJECT  = 2'd1;
  localparam kind_t KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic load_req;
    logic scan_start;
    logic scan_run;
    logic rm_rd;
    logic rm_wr;
    logic rm_best;
    logic post_wr;
    logic hold_load;
    logic hold_clear;
    logic out_load;
    logic out_resp;
    logic out_last;
    logic clear_all;
    logic set_shut;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic drop;
    logic ok;
    logic due;
    logic hold_v;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// File: sv/dtq_ifs.sv
// Request and result channel interfaces of the deadline task queue.
interface dtq_in_if;
  import dtq_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [ID_W-1:0]   task_id;
  logic [TIME_W-1:0] deadline;
  logic [TIME_W-1:0] now_time;
  logic              drop_pending;

  modport source (output valid, action, task_id, deadline, now_time, drop_pending,
                  input ready);
  modport sink (input valid, action, task_id, deadline, now_time, drop_pending,
                output ready);
endinterface

interface dtq_out_if;
  import dtq_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   task_id_res;
  logic              last;

  modport source (output valid, kind, task_id_res, last, input ready);
  modport sink (input valid, kind, task_id_res, last, output ready);
endinterface

// File: sv/dtq_dp.sv
// Datapath: task store, scan compare, request, hold and result registers.
`include "deadline_task_queue_defines.svh"

module dtq_dp #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dtq_pkg::cmd_t             cmd,
  output dtq_pkg::sts_t             sts,
  input  logic [dtq_pkg::ACT_W-1:0]  in_action,
  input  logic [dtq_pkg::ID_W-1:0]   in_task_id,
  input  logic [dtq_pkg::TIME_W-1:0] in_deadline,
  input  logic [dtq_pkg::TIME_W-1:0] in_now_time,
  input  logic                      in_drop_pending,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [dtq_pkg::KIND_W-1:0] out_kind,
  output logic [dtq_pkg::ID_W-1:0]   out_task_id_res,
  output logic                      out_last
);
  import dtq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [TIME_BITS-1:0] mem_dl [CAPACITY];
  logic [ID_BITS-1:0]   mem_id [CAPACITY];

  act_t                 act_r;
  logic [ID_BITS-1:0]   id_r;
  logic [TIME_BITS-1:0] dl_r;
  logic [TIME_BITS-1:0] now_r;
  logic                 drop_r;

  logic [CNT_W-1:0]     count_r;
  logic                 shut_r;

  logic [CNT_W-1:0]     rd_ptr_r;
  logic                 cmp_v_r;
  logic [IDX_W-1:0]     cmp_slot_r;
  logic [TIME_BITS-1:0] rd_dl_r;
  logic [ID_BITS-1:0]   rd_id_r;

  logic                 found_r;
  logic [IDX_W-1:0]     found_slot_r;
  logic                 best_v_r;
  logic [TIME_BITS-1:0] best_dl_r;
  logic [ID_BITS-1:0]   best_id_r;
  logic [IDX_W-1:0]     best_slot_r;

  logic                 hold_v_r;
  logic [ID_BITS-1:0]   hold_id_r;

  logic                 out_valid_r;
  kind_t                out_kind_r;
  logic [ID_W-1:0]      out_id_r;
  logic                 out_last_r;

  logic [CNT_W-1:0]     cnt_m1;
  logic [IDX_W-1:0]     rd_addr;
  logic                 issue;
  logic                 better;
  logic                 full;
  logic                 ok;
  logic                 we;
  logic [IDX_W-1:0]     wa;
  logic [TIME_BITS-1:0] wd_dl;
  logic [ID_BITS-1:0]   wd_id;
  logic [IDX_W-1:0]     rm_slot;
  logic                 out_free;

  assign cnt_m1  = count_r - CNT_W'(1);
  assign issue   = cmd.scan_run && (rd_ptr_r < count_r);
  assign rd_addr = cmd.rm_rd ? cnt_m1[IDX_W-1:0] : rd_ptr_r[IDX_W-1:0];
  assign better  = !best_v_r || (rd_dl_r < best_dl_r) ||
                   ((rd_dl_r == best_dl_r) && (rd_id_r < best_id_r));
  assign full    = (count_r == CNT_W'(CAPACITY));
  assign ok      = (act_r == ACT_POST) ? (!shut_r && !found_r && !full)
                                       : (!shut_r && found_r);
  assign rm_slot = cmd.rm_best ? best_slot_r : found_slot_r;
  assign we      = cmd.rm_wr || cmd.post_wr;
  assign wa      = cmd.rm_wr ? rm_slot : count_r[IDX_W-1:0];
  assign wd_dl   = cmd.rm_wr ? rd_dl_r : dl_r;
  assign wd_id   = cmd.rm_wr ? rd_id_r : id_r;
  assign out_free = !out_valid_r || out_ready;

  // Task store with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_dl[wa] <= wd_dl;
      mem_id[wa] <= wd_id;
    end
    rd_dl_r <= mem_dl[rd_addr];
    rd_id_r <= mem_id[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r  <= in_action;
      id_r   <= ID_BITS'(in_task_id);
      dl_r   <= TIME_BITS'(in_deadline);
      now_r  <= TIME_BITS'(in_now_time);
      drop_r <= in_drop_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      shut_r  <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        count_r <= '0;
      end else if (cmd.rm_wr) begin
        count_r <= cnt_m1;
      end else if (cmd.post_wr) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.clear_all || cmd.set_shut) begin
        shut_r <= 1'b1;
      end
    end
  end

  // Scan: one read issued per cycle, compared the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      cmp_v_r  <= 1'b0;
      found_r  <= 1'b0;
      best_v_r <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_ptr_r <= '0;
      cmp_v_r  <= 1'b0;
      found_r  <= 1'b0;
      best_v_r <= 1'b0;
    end else begin
      cmp_v_r <= issue;
      if (issue) begin
        rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      end
      if (cmp_v_r) begin
        if (rd_id_r == id_r) begin
          found_r <= 1'b1;
        end
        if (better) begin
          best_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_slot_r <= rd_ptr_r[IDX_W-1:0];
    if (cmp_v_r && !cmd.scan_start) begin
      if (rd_id_r == id_r) begin
        found_slot_r <= cmp_slot_r;
      end
      if (better) begin
        best_dl_r   <= rd_dl_r;
        best_id_r   <= rd_id_r;
        best_slot_r <= cmp_slot_r;
      end
    end
  end

  // The held release waits until we know whether another task follows it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (cmd.hold_load) begin
      hold_v_r <= 1'b1;
    end else if (cmd.hold_clear) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_id_r <= best_id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_resp) begin
        out_kind_r <= ok ? KIND_ACCEPT : KIND_REJECT;
        out_id_r   <= ID_W'(id_r);
      end else begin
        out_kind_r <= KIND_RELEASE;
        out_id_r   <= ID_W'(hold_id_r);
      end
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_task_id_res = out_id_r;
  assign out_last        = out_last_r;

  always_comb begin
    sts.act       = act_r;
    sts.drop      = drop_r;
    sts.ok        = ok;
    sts.due       = best_v_r && ((act_r == ACT_SHUTDOWN) || (best_dl_r < now_r));
    sts.hold_v    = hold_v_r;
    sts.scan_done = !(rd_ptr_r < count_r) && !cmp_v_r;
    sts.out_free  = out_free;
  end

  `DTQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(CAPACITY))
  `DTQ_ASSERT_IMPL(a_post_room, clk, rst_n, cmd.post_wr, count_r < CNT_W'(CAPACITY))
  `DTQ_ASSERT_IMPL(a_remove_nonempty, clk, rst_n, cmd.rm_wr, count_r != '0)
  `DTQ_ASSERT_NEXT(a_shut_sticky, clk, rst_n, shut_r, shut_r)

endmodule

// File: sv/dtq_ctrl.sv
// Controller state machine that sequences scans, removals and results.
`include "deadline_task_queue_defines.svh"

module dtq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dtq_pkg::sts_t sts,
  output dtq_pkg::cmd_t cmd
);
  import dtq_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SCAN    = 8'b0000_0010,
    S_DECIDE  = 8'b0000_0100,
    S_MV_RD   = 8'b0000_1000,
    S_MV_WR   = 8'b0001_0000,
    S_RESP    = 8'b0010_0000,
    S_REL_OUT = 8'b0100_0000,
    S_FIN_OUT = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req   = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.act)
          ACT_POST: begin
            state_nxt = S_RESP;
          end
          ACT_CANCEL: begin
            state_nxt = sts.ok ? S_MV_RD : S_RESP;
          end
          default: begin
            if ((sts.act == ACT_SHUTDOWN) && sts.drop) begin
              cmd.clear_all = 1'b1;
              state_nxt     = S_IDLE;
            end else if (sts.due) begin
              if (sts.hold_v) begin
                state_nxt = S_REL_OUT;
              end else begin
                cmd.hold_load = 1'b1;
                state_nxt     = S_MV_RD;
              end
            end else if (sts.hold_v) begin
              state_nxt = S_FIN_OUT;
            end else begin
              cmd.set_shut = (sts.act == ACT_SHUTDOWN);
              state_nxt    = S_IDLE;
            end
          end
        endcase
      end
      S_MV_RD: begin
        cmd.rm_rd = 1'b1;
        state_nxt = S_MV_WR;
      end
      S_MV_WR: begin
        cmd.rm_wr   = 1'b1;
        cmd.rm_best = (sts.act != ACT_CANCEL);
        if (sts.act == ACT_CANCEL) begin
          state_nxt = S_RESP;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_resp = 1'b1;
          cmd.out_last = 1'b1;
          cmd.post_wr  = (sts.act == ACT_POST) && sts.ok;
          state_nxt    = S_IDLE;
        end
      end
      S_REL_OUT: begin
        // Another task is due, so the held one is not the final release.
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.hold_load = 1'b1;
          state_nxt     = S_MV_RD;
        end
      end
      S_FIN_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.hold_clear = 1'b1;
          cmd.set_shut   = (sts.act == ACT_SHUTDOWN);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `DTQ_ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)
  `DTQ_ASSERT_IMPL(a_idle_no_hold, clk, rst_n, state_r == S_IDLE, !sts.hold_v)

endmodule

// File: sv/deadline_task_queue.sv
// Top level of the deadline task queue: controller plus datapath.
//
//   channel   direction  payload
//   in_req    sink       action, task_id, deadline, now_time, drop_pending
//   out_res   source     kind, task_id_res, last
//
// With N tasks pending, a post or cancel scans all N stored entries before
// it answers; a tick or flushing shutdown rescans for each released task.
// Each scan reads the task store, with one write and one registered read port,
// one entry per cycle. Reset clears the task count and the shutdown flag;
// the store contents are left undefined and need no clearing pass. A stalled
// result output holds the block in the state that loads its next result.
module deadline_task_queue #(
  parameter int CAPACITY  = 16,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16
) (
  input logic      clk,
  input logic      rst_n,
  dtq_in_if.sink   in_req,
  dtq_out_if.source out_res
);
  import dtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dtq_dp #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_req.action),
    .in_task_id      (in_req.task_id),
    .in_deadline     (in_req.deadline),
    .in_now_time     (in_req.now_time),
    .in_drop_pending (in_req.drop_pending),
    .out_ready       (out_res.ready),
    .out_valid       (out_res.valid),
    .out_kind        (out_res.kind),
    .out_task_id_res (out_res.task_id_res),
    .out_last        (out_res.last)
  );

endmodule
